[hdl/assert_macros.svh]
// assertion helpers shared by the rtl files
// both sample on the rising edge of clk and are off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/ktsa_pkg.sv]
`timescale 1ns / 1ps
package ktsa_pkg;

  // port width of every key mask
  localparam int KEY_BITS = 16;
  localparam int KEY_WIDTH_DEF = 16;

  // handheld key layout
  localparam int BIT_A     = 0;
  localparam int BIT_START = 3;
  localparam int BIT_R     = 8;
  localparam int BIT_L     = 9;
  localparam int BIT_X     = 10;
  localparam int BIT_Y     = 11;

  // register indexes on the config port
  localparam logic [1:0] CFG_BUTTON_MODE     = 2'd0;
  localparam logic [1:0] CFG_CONTINUE_DELAY  = 2'd1;
  localparam logic [1:0] CFG_START_DELAY     = 2'd2;

  localparam logic [7:0] CONTINUE_DELAY_RST = 8'd4;
  localparam logic [7:0] START_DELAY_RST    = 8'd8;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_START_X = 2'd1,
    MODE_SWAP_XY = 2'd2,
    MODE_L_AS_A  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    VAL_OK       = 2'd0,
    VAL_X_BAD    = 2'd1,
    VAL_Y_BAD    = 2'd2,
    VAL_BOTH_BAD = 2'd3
  } validity_t;

  typedef struct packed {
    mode_t      button_mode;
    logic [7:0] continue_delay;
    logic [7:0] start_delay;
  } cfg_t;

  typedef struct packed {
    logic                lid_closed;
    logic [KEY_BITS-1:0] pad_keys;
    logic [KEY_BITS-1:0] injected_keys;
    logic [7:0]          sample_x;
    logic [7:0]          sample_y;
    validity_t           sample_validity;
    logic                sample_contact;
  } item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] keys_new;
    logic [KEY_BITS-1:0] keys_held;
    logic [KEY_BITS-1:0] keys_new_or_repeat;
    logic [7:0]          touch_x;
    logic [7:0]          touch_y;
    logic                touch_new;
    logic                touch_held;
  } result_t;

  typedef struct packed {
    logic       hold;
    logic [7:0] x;
    logic [7:0] y;
  } touch_t;

  function automatic logic [KEY_BITS-1:0] remap_keys(input logic [KEY_BITS-1:0] k,
                                                     input mode_t mode);
    logic [KEY_BITS-1:0] r;
    r = k;
    case (mode)
      MODE_START_X: begin
        if (k[BIT_START]) r[BIT_X] = 1'b1;
      end
      MODE_SWAP_XY: begin
        r[BIT_X] = k[BIT_Y];
        r[BIT_Y] = k[BIT_X];
      end
      MODE_L_AS_A: begin
        if (k[BIT_L]) r[BIT_A] = 1'b1;
        r[BIT_L] = 1'b0;
        r[BIT_R] = 1'b0;
      end
      default: begin
        r = k;
      end
    endcase
    return r;
  endfunction

endpackage

[hdl/keypad_touch_sampler_autorepeat.sv]
`timescale 1ns / 1ps
// keypad and touch frame sampler with key edge detect and autorepeat
//
// input channel: one word per frame (lid flag, pad and injected key masks,
//   touch sample with validity and contact), taken when in_valid is high
//   and in_stall is low
// output channel: one word per frame (new, held and new-or-repeat key masks
//   after button remapping, touch position, touch begin and touch hold),
//   presented with out_valid; the receiver holds it with out_stall
// config port: cfg_we writes cfg_data to the register picked by cfg_index
//   (0 button mode, 1 repeat continue delay, 2 repeat start delay); write
//   only while no frame is in flight
// path: an accepted frame waits in the input register and moves through
//   the frame logic into the output register whenever that register advances
// throughput: one frame per cycle while out_stall is low; the frame logic
//   between the input register and the output register is a single pass of
//   masks, one 8-bit decrement and compare, and a few muxes
// stall: while out_stall holds a waiting word, the input register keeps one
//   more frame and in_stall rises only once both are full
// reset: rst (synchronous) empties both registers, clears the held keys,
//   the repeat countdown and touch state, and loads the register defaults
`include "assert_macros.svh"
module keypad_touch_sampler_autorepeat #(
  parameter int KEY_WIDTH = ktsa_pkg::KEY_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          lid_closed,
  input  logic [ktsa_pkg::KEY_BITS-1:0] pad_keys,
  input  logic [ktsa_pkg::KEY_BITS-1:0] injected_keys,
  input  logic [7:0]                    sample_x,
  input  logic [7:0]                    sample_y,
  input  logic [1:0]                    sample_validity,
  input  logic                          sample_contact,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ktsa_pkg::KEY_BITS-1:0] keys_new,
  output logic [ktsa_pkg::KEY_BITS-1:0] keys_held,
  output logic [ktsa_pkg::KEY_BITS-1:0] keys_new_or_repeat,
  output logic [7:0]                    touch_x_out,
  output logic [7:0]                    touch_y_out,
  output logic                          touch_new_out,
  output logic                          touch_held_out
);
  import ktsa_pkg::*;

  cfg_t                 cfg;
  item_t                in_word;
  item_t                s1_item;
  logic                 s1_valid;
  logic                 advance;
  logic                 lid_frame;
  result_t              result;
  result_t              result_next;

  // frame state
  logic [KEY_WIDTH-1:0] last_keys;
  logic [KEY_WIDTH-1:0] last_keys_next;
  logic [7:0]           countdown;
  logic [7:0]           countdown_next;
  touch_t               touch;
  touch_t               touch_next;

  ktsa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_word.lid_closed      = lid_closed;
  assign in_word.pad_keys        = pad_keys;
  assign in_word.injected_keys   = injected_keys;
  assign in_word.sample_x        = sample_x;
  assign in_word.sample_y        = sample_y;
  assign in_word.sample_validity = validity_t'(sample_validity);
  assign in_word.sample_contact  = sample_contact;

  // output register moves when empty or when its word is taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_word;
    end
  end

  ktsa_frame #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_frame (
    .item           (s1_item),
    .cfg            (cfg),
    .last_keys      (last_keys),
    .countdown      (countdown),
    .touch          (touch),
    .last_keys_next (last_keys_next),
    .countdown_next (countdown_next),
    .touch_next     (touch_next),
    .result         (result_next)
  );

  // frame state and output register advance together, one frame a cycle while advance is high
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_keys <= '0;
      countdown <= '0;
      touch     <= '0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        last_keys <= last_keys_next;
        countdown <= countdown_next;
        touch     <= touch_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result <= result_next;
    end
  end

  assign keys_new           = result.keys_new;
  assign keys_held          = result.keys_held;
  assign keys_new_or_repeat = result.keys_new_or_repeat;
  assign touch_x_out        = result.touch_x;
  assign touch_y_out        = result.touch_y;
  assign touch_new_out      = result.touch_new;
  assign touch_held_out     = result.touch_held;

  // a lid-closed frame moving into the output register
  assign lid_frame = advance && s1_valid && s1_item.lid_closed;

  // a lid-closed frame blanks the word and drops touch hold
  `ASSERT_NEXT(a_lid_blank, lid_frame, !touch.hold && keys_held == '0 && touch_x_out == 8'd0)
  // touch begin only comes with touch held
  `ASSERT_SAME(a_touch_new_held, out_valid && touch_new_out, touch_held_out)
  // new and repeated keys are always a subset of the held keys
  `ASSERT_SAME(a_new_in_held, out_valid, (keys_new & ~keys_held) == '0)
  `ASSERT_SAME(a_rep_in_held, out_valid, (keys_new_or_repeat & ~keys_held) == '0)
  // touch hold in the output word tracks the frame state it came from
  `ASSERT_NEXT(a_hold_tracks, advance && s1_valid, touch_held_out == touch.hold)

endmodule

[hdl/ktsa_cfg.sv]
`timescale 1ns / 1ps
module ktsa_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output ktsa_pkg::cfg_t     cfg
);
  import ktsa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_mode    <= MODE_NORMAL;
      cfg.continue_delay <= CONTINUE_DELAY_RST;
      cfg.start_delay    <= START_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUTTON_MODE:    cfg.button_mode    <= mode_t'(cfg_data[1:0]);
        CFG_CONTINUE_DELAY: cfg.continue_delay <= cfg_data;
        CFG_START_DELAY:    cfg.start_delay    <= cfg_data;
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

endmodule

[hdl/ktsa_frame.sv]
`timescale 1ns / 1ps
module ktsa_frame #(
  parameter int KEY_WIDTH = ktsa_pkg::KEY_WIDTH_DEF
) (
  input  ktsa_pkg::item_t        item,
  input  ktsa_pkg::cfg_t         cfg,
  input  logic [KEY_WIDTH-1:0]   last_keys,
  input  logic [7:0]             countdown,
  input  ktsa_pkg::touch_t       touch,
  output logic [KEY_WIDTH-1:0]   last_keys_next,
  output logic [7:0]             countdown_next,
  output ktsa_pkg::touch_t       touch_next,
  output ktsa_pkg::result_t      result
);
  import ktsa_pkg::*;

  logic [KEY_WIDTH-1:0] raw;
  logic [KEY_WIDTH-1:0] fresh;
  logic [KEY_WIDTH-1:0] rep;
  logic [7:0]           cd_dec;
  logic                 contact;

  // keys above KEY_WIDTH are dropped here
  assign raw    = KEY_WIDTH'(item.pad_keys | item.injected_keys);
  assign fresh  = raw & ~last_keys;
  assign cd_dec = countdown - 8'd1;

  always_comb begin
    rep            = fresh;
    countdown_next = countdown;
    last_keys_next = last_keys;
    touch_next     = touch;
    contact        = item.sample_contact;
    result         = '0;
    if (item.lid_closed) begin
      touch_next.hold = 1'b0;
    end else begin
      // same non-empty set held: run the countdown, fire on zero
      if (raw != '0 && raw == last_keys) begin
        if (cd_dec == 8'd0) begin
          rep            = raw;
          countdown_next = cfg.continue_delay;
        end else begin
          countdown_next = cd_dec;
        end
      end else begin
        countdown_next = cfg.start_delay;
      end
      last_keys_next = raw;

      case (item.sample_validity)
        VAL_OK: begin
          touch_next.x = item.sample_x;
          touch_next.y = item.sample_y;
        end
        VAL_X_BAD: begin
          if (touch.hold) touch_next.y = item.sample_y;
          else contact = 1'b0;
        end
        VAL_Y_BAD: begin
          if (touch.hold) touch_next.x = item.sample_x;
          else contact = 1'b0;
        end
        default: begin
          if (!touch.hold) contact = 1'b0;
        end
      endcase
      touch_next.hold = contact;

      result.keys_new           = remap_keys(KEY_BITS'(fresh), cfg.button_mode);
      result.keys_held          = remap_keys(KEY_BITS'(raw), cfg.button_mode);
      result.keys_new_or_repeat = remap_keys(KEY_BITS'(rep), cfg.button_mode);
      result.touch_x            = touch_next.x;
      result.touch_y            = touch_next.y;
      result.touch_new          = contact & ~touch.hold;
      result.touch_held         = contact;
    end
  end

endmodule
